// ===== design/cst_pkg.sv =====
// Package for the char symbol table: request, result and entry types,
// opcode, status and kind codes, sequencer states, letter test.
// No dependencies.
package cst_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_SEARCH = 2'd2;
	localparam logic [1:0] OP_MODIFY = 2'd3;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_DUP      = 2'd1;
	localparam logic [1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [1:0] STAT_FULL     = 2'd3;

	localparam logic [1:0] KIND_IDENT = 2'd0;
	localparam logic [1:0] KIND_OPER  = 2'd1;
	localparam logic [1:0] KIND_MOD   = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] symbol;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] kind;
		logic [5:0] position;
		logic [6:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [7:0] key;
		logic [1:0] kind;
	} ent_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	function automatic logic is_letter(input logic [7:0] sym);
		return sym inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

endpackage

// ===== design/char_symbol_table.sv =====
// Char symbol table top level: sequencer, count register and result register
// around one entry RAM. Depends on cst_pkg and cst_ram.
//
// A request is taken when start is high and busy is low; busy stays high until
// the result appears on result for exactly one cycle with done high. The entry
// RAM is scanned one entry per cycle from index 0 until the symbol matches or
// count entries are read. A delete then moves each later entry down one slot
// through the same RAM port pair, one entry per cycle. The longest request is
// a delete of entry 0 in a full table. Results cannot be held off by the
// receiver. No clearing pass is needed after reset.
module char_symbol_table
	import cst_pkg::*;
#(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t result
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	state_t         state_q, state_d;
	logic [1:0]     op_q;
	logic [7:0]     sym_q;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  scan_q;
	logic [CW-1:0]  pidx_q;
	logic [CW-1:0]  pidx_m1;
	logic [CW-1:0]  hit_q;
	logic [1:0]     hit_kind_q;
	logic           pend_q;
	logic           done_q;
	rsp_t           result_q, res_d;

	logic           issue, match, scan_end, fin, accept;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	ent_t           ram_wdata, ram_rdata;

	cst_ram #(
		.WIDTH ($bits(ent_t)),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	assign match    = pend_q && (ram_rdata.key == sym_q);
	assign scan_end = !pend_q && (scan_q == count_q);
	assign issue    = busy && (scan_q != count_q);
	assign pidx_m1  = pidx_q - CW'(1);
	assign done     = done_q;
	assign result   = result_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (match) begin
					state_d = (op_q == OP_DELETE) ? S_SHIFT : S_IDLE;
				end else if (scan_end) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (scan_end) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		fin       = 1'b0;
		count_d   = count_q;
		res_d     = '0;
		case (state_q)
			S_SCAN: begin
				if (match) begin
					res_d.kind     = ram_rdata.kind;
					res_d.position = 6'(pidx_q);
					case (op_q)
						OP_INSERT: begin
							fin          = 1'b1;
							res_d.status = STAT_DUP;
						end
						OP_SEARCH: begin
							fin          = 1'b1;
							res_d.status = STAT_OK;
						end
						OP_MODIFY: begin
							fin          = 1'b1;
							res_d.status = STAT_OK;
							res_d.kind   = KIND_MOD;
							ram_we       = 1'b1;
							ram_waddr    = pidx_q[AW-1:0];
							ram_wdata    = '{key: sym_q, kind: KIND_MOD};
						end
						default: ;
					endcase
				end else if (scan_end) begin
					fin = 1'b1;
					if (op_q != OP_INSERT) begin
						res_d.status = STAT_NOTFOUND;
					end else if (count_q == CW'(TABLE_DEPTH)) begin
						res_d.status = STAT_FULL;
					end else begin
						res_d.status   = STAT_OK;
						res_d.kind     = is_letter(sym_q) ? KIND_IDENT : KIND_OPER;
						res_d.position = 6'(count_q);
						ram_we         = 1'b1;
						ram_waddr      = count_q[AW-1:0];
						ram_wdata      = '{key: sym_q, kind: res_d.kind};
						count_d        = count_q + CW'(1);
					end
				end
			end
			S_SHIFT: begin
				if (pend_q) begin
					ram_we    = 1'b1;
					ram_waddr = pidx_m1[AW-1:0];
					ram_wdata = ram_rdata;
				end
				if (scan_end) begin
					fin            = 1'b1;
					res_d.status   = STAT_OK;
					res_d.kind     = hit_kind_q;
					res_d.position = 6'(hit_q);
					count_d        = count_q - CW'(1);
				end
			end
			default: ;
		endcase
		res_d.entry_count = 7'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			pend_q  <= 1'b0;
			scan_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
			if (accept) begin
				scan_q <= '0;
				pend_q <= 1'b0;
			end else if (state_q == S_SCAN && match && op_q == OP_DELETE) begin
				scan_q <= pidx_q + CW'(1);
				pend_q <= 1'b0;
			end else begin
				pend_q <= issue;
				if (issue) scan_q <= scan_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= req.opcode;
			sym_q <= req.symbol;
		end
		if (issue) pidx_q <= scan_q;
		if (match) begin
			hit_q      <= pidx_q;
			hit_kind_q <= ram_rdata.kind;
		end
		if (fin) result_q <= res_d;
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a transfer is still in progress");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transfer did not raise busy");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == STAT_FULL) |-> result.entry_count == 7'(TABLE_DEPTH))
		else $error("table full reported below depth");

endmodule

// ===== design/cst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cst_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== bench/tb_char_symbol_table.sv =====
// Self-checking bench for char_symbol_table: directed and random table
// requests with a shadow table that predicts every response.
// Depends on cst_pkg and the char_symbol_table RTL.
`timescale 1ns / 1ps

module tb_char_symbol_table;
	import cst_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int N_RANDOM    = 1950;
	localparam int DRAIN_WAIT  = 2 * TABLE_DEPTH + 16;

	typedef enum int {
		B_MIXED,
		B_DRAIN,
		B_GROW,
		B_FILL
	} burst_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t result;

	req_t req_backlog[$];
	rsp_t due_rsps[$];
	logic [7:0] seen_syms[$];

	logic [7:0] tbl_key [TABLE_DEPTH];
	logic [1:0] tbl_kind [TABLE_DEPTH];
	int tbl_count = 0;

	int n_reqs = 0;
	int n_taken = 0;
	int n_bad = 0;

	char_symbol_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result)
	);

	always #5 clk = ~clk;

	// Shadow table: applies one request and returns the response it must give.
	function automatic rsp_t apply_request(req_t rq);
		rsp_t r;
		int hit;
		logic alpha;
		r = '0;
		r.status = STAT_OK;
		hit = tbl_count;
		alpha = (rq.symbol >= 8'h41 && rq.symbol <= 8'h5A) ||
			(rq.symbol >= 8'h61 && rq.symbol <= 8'h7A);
		for (int i = tbl_count - 1; i >= 0; i--)
			if (tbl_key[i] == rq.symbol)
				hit = i;
		if (rq.opcode == OP_INSERT) begin
			if (hit < tbl_count) begin
				r.status = STAT_DUP;
				r.kind = tbl_kind[hit];
				r.position = 6'(hit);
			end else if (tbl_count >= TABLE_DEPTH) begin
				r.status = STAT_FULL;
			end else begin
				r.kind = alpha ? KIND_IDENT : KIND_OPER;
				r.position = 6'(tbl_count);
				tbl_key[tbl_count] = rq.symbol;
				tbl_kind[tbl_count] = r.kind;
				tbl_count++;
			end
		end else if (hit == tbl_count) begin
			r.status = STAT_NOTFOUND;
		end else begin
			r.kind = tbl_kind[hit];
			r.position = 6'(hit);
			case (rq.opcode)
				OP_DELETE: begin
					for (int i = hit; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i + 1];
						tbl_kind[i] = tbl_kind[i + 1];
					end
					tbl_count--;
				end
				OP_MODIFY: begin
					tbl_kind[hit] = KIND_MOD;
					r.kind = KIND_MOD;
				end
				default: ;
			endcase
		end
		r.entry_count = 7'(tbl_count);
		return r;
	endfunction

	task automatic queue_req(logic [1:0] op, logic [7:0] sym);
		req_t rq;
		rq.opcode = op;
		rq.symbol = sym;
		req_backlog.push_back(rq);
	endtask

	// Mostly symbols used recently so that lookups hit, the rest any byte.
	function automatic logic [7:0] pick_symbol();
		logic [7:0] s;
		if (seen_syms.size() > 0 && $urandom_range(0, 99) < 60)
			s = seen_syms[$urandom_range(0, seen_syms.size() - 1)];
		else
			s = 8'($urandom);
		seen_syms.push_back(s);
		if (seen_syms.size() > TABLE_DEPTH)
			void'(seen_syms.pop_front());
		return s;
	endfunction

	task automatic queue_random();
		burst_t mode;
		int len;
		int ins_pct;
		int del_pct;
		int r;
		logic [7:0] base;
		logic [7:0] stride;
		logic [7:0] s;
		logic [1:0] op;
		mode = burst_t'($urandom_range(0, 3));
		if (mode == B_FILL) begin
			// distinct symbols, enough to overflow the table
			base = 8'($urandom);
			stride = 8'($urandom_range(0, 127) * 2 + 1);
			len = $urandom_range(TABLE_DEPTH + 2, TABLE_DEPTH + 16);
			for (int i = 0; i < len; i++) begin
				s = base + 8'(i) * stride;
				seen_syms.push_back(s);
				if (seen_syms.size() > TABLE_DEPTH)
					void'(seen_syms.pop_front());
				queue_req(OP_INSERT, s);
			end
			return;
		end
		case (mode)
			B_DRAIN: begin
				ins_pct = 15;
				del_pct = 55;
			end
			B_GROW: begin
				ins_pct = 55;
				del_pct = 15;
			end
			default: begin
				ins_pct = 25;
				del_pct = 25;
			end
		endcase
		len = $urandom_range(40, 160);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < ins_pct)
				op = OP_INSERT;
			else if (r < ins_pct + del_pct)
				op = OP_DELETE;
			else
				op = r[0] ? OP_SEARCH : OP_MODIFY;
			queue_req(op, pick_symbol());
		end
	endtask

	initial begin
		// empty table, every lookup misses
		queue_req(OP_SEARCH, 8'h41);
		queue_req(OP_DELETE, 8'h00);
		queue_req(OP_MODIFY, 8'hFF);
		// letter range edges and bytes above 0x7F
		queue_req(OP_INSERT, 8'h41);
		queue_req(OP_INSERT, 8'h5A);
		queue_req(OP_INSERT, 8'h61);
		queue_req(OP_INSERT, 8'h7A);
		queue_req(OP_INSERT, 8'h40);
		queue_req(OP_INSERT, 8'h5B);
		queue_req(OP_INSERT, 8'h60);
		queue_req(OP_INSERT, 8'h7B);
		queue_req(OP_INSERT, 8'h00);
		queue_req(OP_INSERT, 8'hFF);
		queue_req(OP_INSERT, 8'h80);
		queue_req(OP_INSERT, 8'hC1);
		queue_req(OP_INSERT, 8'h41);
		queue_req(OP_SEARCH, 8'hFF);
		queue_req(OP_MODIFY, 8'h7A);
		queue_req(OP_INSERT, 8'h7A);
		queue_req(OP_SEARCH, 8'h55);
		// delete from the middle, the head and the tail
		queue_req(OP_DELETE, 8'h61);
		queue_req(OP_SEARCH, 8'hFF);
		queue_req(OP_DELETE, 8'h41);
		queue_req(OP_DELETE, 8'hC1);
		queue_req(OP_MODIFY, 8'h42);
		while (req_backlog.size() < 25 + N_RANDOM)
			queue_random();
		n_reqs = req_backlog.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (req_backlog.size() > 0 || start || due_rsps.size() > 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (n_bad == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin : drive_reqs
		int gap_pct;
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			gap_pct = (n_taken < n_reqs / 3) ? 24 : (n_taken < 2 * n_reqs / 3) ? 61 : 0;
			if (start && !busy) begin
				due_rsps.push_back(apply_request(req));
				n_taken++;
			end
			if (!start || !busy) begin
				if (req_backlog.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
					start <= 1'b1;
					req <= req_backlog.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_bad++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && done) begin
			if (due_rsps.size() == 0) begin
				$error("response transfer with no request outstanding");
				n_bad++;
			end else begin
				want = due_rsps.pop_front();
				check_field("status", want.status, result.status);
				check_field("kind", want.kind, result.kind);
				check_field("position", want.position, result.position);
				check_field("entry_count", want.entry_count, result.entry_count);
			end
		end
	end

endmodule

// ===== files.f =====
design/cst_pkg.sv
design/cst_ram.sv
design/char_symbol_table.sv
bench/tb_char_symbol_table.sv
